[sv/hpm_pkg.sv]
// Shared constants, register map and stage record types for the haptic pulse map.
package hpm_pkg;

    localparam int CHANNELS  = 8;
    localparam int ACT_STEPS = 16;   // quotient bits of the activation divide
    localparam int PRD_STEPS = 20;   // quotient bits of the period divide

    localparam logic [16:0] Q16_ONE       = 17'd65536;
    localparam logic [16:0] FREQ_MIN      = 17'd100;
    localparam logic [19:0] PERIOD_MAX_US = 20'd1000000;
    localparam logic [26:0] CENTIHZ_TO_US = 27'd100000000;

    localparam logic [1:0] MODE_INTENSITY = 2'd0;
    localparam logic [1:0] MODE_FREQ      = 2'd1;
    localparam logic [1:0] MODE_DUTY      = 2'd2;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_NEAR      = 3'd1;
    localparam logic [2:0] REG_FAR       = 3'd2;
    localparam logic [2:0] REG_LOW_FREQ  = 3'd3;
    localparam logic [2:0] REG_HIGH_FREQ = 3'd4;
    localparam logic [2:0] REG_DUTY      = 3'd5;
    localparam logic [2:0] REG_SET_FREQ  = 3'd6;
    localparam logic [2:0] REG_FLOOR     = 3'd7;

    typedef struct packed {
        logic [2:0] ch;
        logic       ok;
    } act_tag_t;

    typedef struct packed {
        logic [2:0]  ch;
        logic        ok;
        logic [1:0]  mode;
        logic [16:0] a;
        logic [16:0] inten;
    } ctx_t;

    typedef struct packed {
        logic [2:0]  ch;
        logic [16:0] inten;
        logic [19:0] on_us;
        logic [19:0] off_us;
        logic        tv;
    } res_t;

    function automatic logic [16:0] clamp_q16(input logic [16:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage

[sv/distance_to_haptic_pulse_map_core.sv]
// Top level: register port, intensity and frequency mapping, timing split and output.
//
// Maps one channel's distance to its haptic drive settings. A request is taken every
// clock while the output side keeps up; on its way to the output a request passes through
// two setup stages and sixteen divider stages for the squared-distance activation, one
// multiply stage, one setup stage and twenty divider stages for the pulse period, one
// stage for the on/off split and the output register. The pipeline stalls as a whole
// only when the output register and its skid entry are both full. Registers must be
// written while the block holds no request in flight.
module distance_to_haptic_pulse_map_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] channel, [18:3] distance_mm
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [2:0] channel_out, [19:3] intensity_q16,
                                   // [39:20] on_time_us, [59:40] off_time_us
    output logic        m_tuser,   // [0] timing_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  mode_reg;
    logic [15:0] near_reg;
    logic [15:0] far_reg;
    logic [16:0] low_freq_reg;
    logic [16:0] high_freq_reg;
    logic [16:0] duty_reg;
    logic [16:0] set_freq_reg;
    logic [16:0] floor_reg;

    logic        wr;
    logic        en;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= hpm_pkg::MODE_INTENSITY;
            near_reg      <= 16'd100;
            far_reg       <= 16'd1000;
            low_freq_reg  <= 17'd100;
            high_freq_reg <= 17'd1000;
            duty_reg      <= 17'd32768;
            set_freq_reg  <= 17'd500;
            floor_reg     <= 17'd6554;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                hpm_pkg::REG_MODE:      mode_reg      <= pwdata[1:0];
                hpm_pkg::REG_NEAR:      near_reg      <= pwdata[15:0];
                hpm_pkg::REG_FAR:       far_reg       <= pwdata[15:0];
                hpm_pkg::REG_LOW_FREQ:  low_freq_reg  <= pwdata[16:0];
                hpm_pkg::REG_HIGH_FREQ: high_freq_reg <= pwdata[16:0];
                hpm_pkg::REG_DUTY:      duty_reg      <= pwdata[16:0];
                hpm_pkg::REG_SET_FREQ:  set_freq_reg  <= pwdata[16:0];
                hpm_pkg::REG_FLOOR:     floor_reg     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            hpm_pkg::REG_MODE:      prdata = 32'(mode_reg);
            hpm_pkg::REG_NEAR:      prdata = 32'(near_reg);
            hpm_pkg::REG_FAR:       prdata = 32'(far_reg);
            hpm_pkg::REG_LOW_FREQ:  prdata = 32'(low_freq_reg);
            hpm_pkg::REG_HIGH_FREQ: prdata = 32'(high_freq_reg);
            hpm_pkg::REG_DUTY:      prdata = 32'(duty_reg);
            hpm_pkg::REG_SET_FREQ:  prdata = 32'(set_freq_reg);
            hpm_pkg::REG_FLOOR:     prdata = 32'(floor_reg);
            default:                prdata = '0;
        endcase
    end

    // ---------------- activation ----------------
    logic                 act_valid;
    hpm_pkg::act_tag_t    act_tag;
    logic [16:0]          act_a;

    assign s_tready = en;

    hpm_act u_act (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_ch     (s_tdata[2:0]),
        .in_dist   (s_tdata[18:3]),
        .near      (near_reg),
        .far       (far_reg),
        .out_valid (act_valid),
        .out_tag   (act_tag),
        .out_a     (act_a)
    );

    // ---------------- intensity / frequency products ----------------
    logic [16:0] fl;
    logic        up_dir;
    logic [16:0] fdiff;

    assign fl     = hpm_pkg::clamp_q16(floor_reg);
    assign up_dir = (high_freq_reg >= low_freq_reg);
    assign fdiff  = up_dir ? (high_freq_reg - low_freq_reg) : (low_freq_reg - high_freq_reg);

    logic              m1_v_reg;
    hpm_pkg::act_tag_t m1_tag_reg;
    logic [16:0]       m1_a_reg;
    logic [33:0]       m1_pi_reg;
    logic [33:0]       m1_pf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_v_reg <= 1'b0;
        else if (en)
            m1_v_reg <= act_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_tag_reg <= act_tag;
            m1_a_reg   <= act_a;
            m1_pi_reg  <= 34'(act_a) * 34'(hpm_pkg::Q16_ONE - fl);
            m1_pf_reg  <= 34'(act_a) * 34'(fdiff);
        end
    end

    logic [16:0]   f_step;
    logic [16:0]   f_act;
    logic [16:0]   f_sel;
    hpm_pkg::ctx_t ctx_in;

    assign f_step = m1_pf_reg[32:16];
    assign f_act  = up_dir ? (low_freq_reg + f_step) : (low_freq_reg - f_step);
    assign f_sel  = (mode_reg == hpm_pkg::MODE_DUTY) ? set_freq_reg : f_act;

    always_comb
    begin
        ctx_in.ch    = m1_tag_reg.ch;
        ctx_in.ok    = m1_tag_reg.ok;
        ctx_in.mode  = mode_reg;
        ctx_in.a     = m1_a_reg;
        ctx_in.inten = (m1_tag_reg.ok && (m1_a_reg != 17'd0)) ? (fl + m1_pi_reg[32:16]) : 17'd0;
    end

    // ---------------- period ----------------
    logic          prd_valid;
    hpm_pkg::ctx_t prd_ctx;
    logic [19:0]   prd_period;

    hpm_prd u_prd (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (m1_v_reg),
        .in_f       (f_sel),
        .in_ctx     (ctx_in),
        .out_valid  (prd_valid),
        .out_ctx    (prd_ctx),
        .out_period (prd_period)
    );

    // ---------------- on / off split ----------------
    logic [16:0] duty;
    logic        is_freq;

    assign duty    = hpm_pkg::clamp_q16(duty_reg);
    assign is_freq = (prd_ctx.mode == hpm_pkg::MODE_FREQ);

    logic          m3_v_reg;
    hpm_pkg::ctx_t m3_ctx_reg;
    logic [19:0]   m3_period_reg;
    logic [36:0]   m3_p1_reg;
    logic [36:0]   m3_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_v_reg <= 1'b0;
        else if (en)
            m3_v_reg <= prd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m3_ctx_reg    <= prd_ctx;
            m3_period_reg <= prd_period;
            m3_p1_reg     <= 37'(prd_period) * 37'(is_freq ? duty : prd_ctx.a);
            m3_p2_reg     <= 37'(prd_period) * 37'(hpm_pkg::Q16_ONE - duty);
        end
    end

    logic          m3_freq;
    logic          m3_tv;
    logic [19:0]   on_us;
    logic [19:0]   off_us;
    hpm_pkg::res_t res;

    assign m3_freq = (m3_ctx_reg.mode == hpm_pkg::MODE_FREQ);
    assign m3_tv   = m3_ctx_reg.ok &&
                     (m3_freq || (m3_ctx_reg.mode == hpm_pkg::MODE_DUTY));
    assign on_us   = m3_p1_reg[35:16];
    assign off_us  = m3_freq ? m3_p2_reg[35:16] : (m3_period_reg - on_us);

    always_comb
    begin
        res.ch     = m3_ctx_reg.ch;
        res.inten  = m3_ctx_reg.inten;
        res.on_us  = m3_tv ? on_us : 20'd0;
        res.off_us = m3_tv ? off_us : 20'd0;
        res.tv     = m3_tv;
    end

    hpm_pkg::res_t out_res;

    hpm_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (m3_v_reg && en),
        .push_data (res),
        .up_ready  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {4'd0, out_res.off_us, out_res.on_us, out_res.inten, out_res.ch};
    assign m_tuser = out_res.tv;

endmodule

[sv/hpm_act.sv]
// Activation pipeline: span setup, squaring and a restoring divider, one quotient bit a stage.
module hpm_act (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0]            in_ch,
    input  logic [15:0]           in_dist,
    input  logic [15:0]           near,
    input  logic [15:0]           far,
    output logic                  out_valid,
    output hpm_pkg::act_tag_t     out_tag,
    output logic [16:0]           out_a
);

    localparam int N = hpm_pkg::ACT_STEPS;

    logic                  v0_reg;
    hpm_pkg::act_tag_t     tag0_reg;
    logic                  zero0_reg;
    logic                  full0_reg;
    logic [15:0]           num0_reg;
    logic [15:0]           span0_reg;

    logic                  v_reg    [0:N];
    hpm_pkg::act_tag_t     tag_reg  [0:N];
    logic                  zero_reg [0:N];
    logic                  full_reg [0:N];
    logic [31:0]           rem_reg  [0:N];
    logic [31:0]           d_reg    [0:N];
    logic [N-1:0]          q_reg    [0:N];

    hpm_pkg::act_tag_t     in_tag;

    always_comb
    begin
        in_tag.ch = in_ch;
        in_tag.ok = ({1'b0, in_ch} < 4'(hpm_pkg::CHANNELS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= in_valid;
            v_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag0_reg     <= in_tag;
            zero0_reg    <= (in_dist >= far);
            full0_reg    <= (in_dist <= near);
            num0_reg     <= far - in_dist;
            span0_reg    <= far - near;
            // squares of the two spans; the divide starts from here
            tag_reg[0]   <= tag0_reg;
            zero_reg[0]  <= zero0_reg;
            full_reg[0]  <= full0_reg;
            rem_reg[0]   <= 32'(num0_reg) * 32'(num0_reg);
            d_reg[0]     <= 32'(span0_reg) * 32'(span0_reg);
            q_reg[0]     <= '0;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_div
        logic [32:0] trial;
        logic        ge;

        assign trial = {rem_reg[k-1], 1'b0};
        assign ge    = (trial >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k]  <= tag_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                full_reg[k] <= full_reg[k-1];
                d_reg[k]    <= d_reg[k-1];
                rem_reg[k]  <= ge ? 32'(trial - {1'b0, d_reg[k-1]}) : 32'(trial);
                q_reg[k]    <= {q_reg[k-1][N-2:0], ge};
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_tag   = tag_reg[N];
    assign out_a     = zero_reg[N] ? 17'd0 :
                       full_reg[N] ? hpm_pkg::Q16_ONE : 17'(q_reg[N]);

endmodule

[sv/hpm_prd.sv]
// Period pipeline: 100000000 / frequency by restoring division, one quotient bit a stage.
module hpm_prd (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [16:0]       in_f,
    input  hpm_pkg::ctx_t     in_ctx,
    output logic              out_valid,
    output hpm_pkg::ctx_t     out_ctx,
    output logic [19:0]       out_period
);

    localparam int N     = hpm_pkg::PRD_STEPS;
    localparam int REM_W = 27;
    localparam int CMP_W = 17 + N - 1;

    logic              v_reg   [0:N];
    hpm_pkg::ctx_t     ctx_reg [0:N];
    logic              sat_reg [0:N];
    logic [16:0]       f_reg   [0:N];
    logic [REM_W-1:0]  rem_reg [0:N];
    logic [N-1:0]      q_reg   [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            // anything under 1 Hz, zero included, pins the period at its ceiling
            sat_reg[0] <= (in_f < hpm_pkg::FREQ_MIN);
            f_reg[0]   <= in_f;
            rem_reg[0] <= hpm_pkg::CENTIHZ_TO_US;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_div
        localparam int B = N - k;
        logic [CMP_W-1:0] sub;
        logic             ge;

        assign sub = CMP_W'(f_reg[k-1]) << B;
        assign ge  = (CMP_W'(rem_reg[k-1]) >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (en)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                f_reg[k]   <= f_reg[k-1];
                rem_reg[k] <= ge ? REM_W'(CMP_W'(rem_reg[k-1]) - sub) : rem_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][N-2:0], ge};
            end
        end
    end

    assign out_valid  = v_reg[N];
    assign out_ctx    = ctx_reg[N];
    assign out_period = sat_reg[N] ? hpm_pkg::PERIOD_MAX_US : q_reg[N];

endmodule

[sv/hpm_skid.sv]
// Output register with a skid entry; its ready toward the pipeline is registered.
module hpm_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hpm_pkg::res_t     push_data,
    output logic              up_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output hpm_pkg::res_t     out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    hpm_pkg::res_t     out_reg;
    hpm_pkg::res_t     skid_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign up_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= push_data;
            else
                skid_reg <= push_data;
        end
    end

endmodule

[sv/hpm_chk.sv]
// Port-level checks for the haptic pulse map, bound to the top level.
module hpm_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_inten: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:3] <= 17'd65536))
        else $error("intensity above full scale");

    a_notime: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[59:20] == 40'd0))
        else $error("times present without timing_valid");

    a_period: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |->
            (21'(m_tdata[39:20]) + 21'(m_tdata[59:40]) <= 21'd1000000))
        else $error("on plus off exceeds the longest period");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:60] == 4'd0))
        else $error("pad bits set");

endmodule

bind distance_to_haptic_pulse_map_core hpm_chk u_hpm_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
